/* rtl/core/sexp_pkg.sv */
// ----------------------------------------------------------------------------
// sexp_pkg: shared types and constants of the s-expression tokenizer
// Scanner modes, token kind codes, character codes and result records.
// ----------------------------------------------------------------------------
package sexp_pkg;

    // Longest token text that is passed on; the rest is dropped and flagged.
    localparam int MAX_TEXT_LENGTH = 1024;
    localparam int TEXT_LEN_W      = $clog2(MAX_TEXT_LENGTH + 1);
    localparam logic [TEXT_LEN_W-1:0] TEXT_LEN_MAX = TEXT_LEN_W'(MAX_TEXT_LENGTH);

    // Queue between scanner and result serializer.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_HASH,
        MODE_HASHQ,
        MODE_NUMWORD,
        MODE_DOT,
        MODE_SYMWORD
    } scan_mode_t;

    localparam logic [3:0] KIND_EOF     = 4'd0;
    localparam logic [3:0] KIND_ERROR   = 4'd1;
    localparam logic [3:0] KIND_OPEN    = 4'd2;
    localparam logic [3:0] KIND_CLOSE   = 4'd3;
    localparam logic [3:0] KIND_SYMBOL  = 4'd4;
    localparam logic [3:0] KIND_STRING  = 4'd5;
    localparam logic [3:0] KIND_INTEGER = 4'd6;
    localparam logic [3:0] KIND_REAL    = 4'd7;
    localparam logic [3:0] KIND_PATOPEN = 4'd8;
    localparam logic [3:0] KIND_DOT     = 4'd9;
    localparam logic [3:0] KIND_TRUE    = 4'd10;
    localparam logic [3:0] KIND_FALSE   = 4'd11;

    localparam logic RES_TEXT = 1'b0;
    localparam logic RES_END  = 1'b1;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_POINT  = 8'd46;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_QMARK  = 8'd63;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_LOW_F  = 8'd102;
    localparam logic [7:0] CH_LOW_N  = 8'd110;
    localparam logic [7:0] CH_LOW_T  = 8'd116;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] text_byte;
        logic [3:0] token_kind;
        logic       truncated;
    } result_t;

    // One queue entry: all results of one input beat (one or two).
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    function automatic result_t make_text(logic [7:0] b);
        result_t r;
        r.result_kind = RES_TEXT;
        r.text_byte   = b;
        r.token_kind  = KIND_EOF;
        r.truncated   = 1'b0;
        return r;
    endfunction

    function automatic result_t make_end(logic [3:0] k, logic tr);
        result_t r;
        r.result_kind = RES_END;
        r.text_byte   = 8'd0;
        r.token_kind  = k;
        r.truncated   = tr;
        return r;
    endfunction

endpackage

/* rtl/core/sexp_front.sv */
// ----------------------------------------------------------------------------
// sexp_front: character scanner
// Classifies one byte per beat and packs the results it causes into a queue entry.
// ----------------------------------------------------------------------------
module sexp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           in_byte,
    input  logic                 is_end,
    output logic                 push,
    output sexp_pkg::entry_t     push_entry
);

    sexp_pkg::scan_mode_t                mode_reg, mode_next;
    logic                                digit_reg, digit_next;
    logic [1:0]                          point_reg, point_next;
    logic                                nondig_reg, nondig_next;
    logic [sexp_pkg::TEXT_LEN_W-1:0]     len_reg, len_next;
    logic                                trunc_reg, trunc_next;

    logic       c_ws, c_digit, c_delim, c_term;
    logic       room0, room1;
    logic [7:0] esc_char;
    logic [3:0] word_kind;
    logic [sexp_pkg::TEXT_LEN_W:0] len_plus1;

    // what an idle scanner does with the byte
    sexp_pkg::scan_mode_t idle_mode;
    logic                 idle_emit;
    sexp_pkg::result_t    idle_rec;

    sexp_pkg::result_t r0, r1;
    logic [1:0]        n_res;

    assign c_ws    = (in_byte == sexp_pkg::CH_SPACE)
                  || (in_byte >= sexp_pkg::CH_TAB && in_byte <= sexp_pkg::CH_CR);
    assign c_digit = (in_byte >= sexp_pkg::CH_ZERO) && (in_byte <= sexp_pkg::CH_NINE);
    assign c_delim = (in_byte == sexp_pkg::CH_QUOTE) || (in_byte == sexp_pkg::CH_LPAREN)
                  || (in_byte == sexp_pkg::CH_RPAREN) || (in_byte == sexp_pkg::CH_SEMI);
    assign c_term  = is_end || c_ws || c_delim;

    assign len_plus1 = {1'b0, len_reg} + 1'b1;
    assign room0     = len_reg < sexp_pkg::TEXT_LEN_MAX;
    assign room1     = len_plus1 < {1'b0, sexp_pkg::TEXT_LEN_MAX};

    assign esc_char = (in_byte == sexp_pkg::CH_LOW_N) ? sexp_pkg::CH_LF :
                      (in_byte == sexp_pkg::CH_LOW_T) ? sexp_pkg::CH_TAB : in_byte;

    assign word_kind = (nondig_reg || !digit_reg || point_reg >= 2'd2) ? sexp_pkg::KIND_SYMBOL :
                       (point_reg == 2'd1) ? sexp_pkg::KIND_REAL : sexp_pkg::KIND_INTEGER;

    always_comb
    begin
        idle_mode = sexp_pkg::MODE_IDLE;
        idle_emit = 1'b0;
        idle_rec  = sexp_pkg::make_text(in_byte);
        priority if (c_ws)
        begin
            idle_mode = sexp_pkg::MODE_IDLE;
        end
        else if (in_byte == sexp_pkg::CH_SEMI)
        begin
            idle_mode = sexp_pkg::MODE_COMMENT;
        end
        else if (in_byte == sexp_pkg::CH_LPAREN)
        begin
            idle_emit = 1'b1;
            idle_rec  = sexp_pkg::make_end(sexp_pkg::KIND_OPEN, 1'b0);
        end
        else if (in_byte == sexp_pkg::CH_RPAREN)
        begin
            idle_emit = 1'b1;
            idle_rec  = sexp_pkg::make_end(sexp_pkg::KIND_CLOSE, 1'b0);
        end
        else if (in_byte == sexp_pkg::CH_QUOTE)
        begin
            idle_mode = sexp_pkg::MODE_STRING;
        end
        else if (in_byte == sexp_pkg::CH_HASH)
        begin
            idle_mode = sexp_pkg::MODE_HASH;
        end
        else if (c_digit || in_byte == sexp_pkg::CH_MINUS)
        begin
            idle_mode = sexp_pkg::MODE_NUMWORD;
            idle_emit = 1'b1;
        end
        else if (in_byte == sexp_pkg::CH_POINT)
        begin
            idle_mode = sexp_pkg::MODE_DOT;
        end
        else
        begin
            idle_mode = sexp_pkg::MODE_SYMWORD;
            idle_emit = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        digit_next  = digit_reg;
        point_next  = point_reg;
        nondig_next = nondig_reg;
        len_next    = len_reg;
        trunc_next  = trunc_reg;
        unique case (mode_reg)
            sexp_pkg::MODE_COMMENT:
            begin
                if (is_end)
                begin
                    mode_next = sexp_pkg::MODE_IDLE;
                    {digit_next, point_next, nondig_next, len_next, trunc_next} = '0;
                end
                else if (in_byte == sexp_pkg::CH_LF)
                begin
                    mode_next = sexp_pkg::MODE_IDLE;
                end
            end
            sexp_pkg::MODE_STRING, sexp_pkg::MODE_ESCAPE:
            begin
                if (is_end || (mode_reg == sexp_pkg::MODE_STRING
                               && in_byte == sexp_pkg::CH_QUOTE))
                begin
                    mode_next = sexp_pkg::MODE_IDLE;
                    {digit_next, point_next, nondig_next, len_next, trunc_next} = '0;
                end
                else if (mode_reg == sexp_pkg::MODE_STRING && in_byte == sexp_pkg::CH_BSLASH)
                begin
                    mode_next = sexp_pkg::MODE_ESCAPE;
                end
                else
                begin
                    mode_next = sexp_pkg::MODE_STRING;
                    if (room0)
                        len_next = len_plus1[sexp_pkg::TEXT_LEN_W-1:0];
                    else
                        trunc_next = 1'b1;
                end
            end
            sexp_pkg::MODE_HASH:
            begin
                if (!is_end && in_byte == sexp_pkg::CH_QMARK)
                begin
                    mode_next = sexp_pkg::MODE_HASHQ;
                end
                else
                begin
                    mode_next = sexp_pkg::MODE_IDLE;
                    {digit_next, point_next, nondig_next, len_next, trunc_next} = '0;
                end
            end
            sexp_pkg::MODE_HASHQ:
            begin
                mode_next = sexp_pkg::MODE_IDLE;
                {digit_next, point_next, nondig_next, len_next, trunc_next} = '0;
            end
            sexp_pkg::MODE_NUMWORD, sexp_pkg::MODE_SYMWORD, sexp_pkg::MODE_DOT:
            begin
                if (c_term)
                begin
                    {digit_next, point_next, nondig_next, len_next, trunc_next} = '0;
                    if (is_end)
                    begin
                        mode_next = sexp_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        mode_next  = idle_mode;
                        digit_next = c_digit;
                        len_next   = sexp_pkg::TEXT_LEN_W'(idle_emit && !idle_rec.result_kind);
                    end
                end
                else if (mode_reg == sexp_pkg::MODE_DOT)
                begin
                    mode_next  = sexp_pkg::MODE_SYMWORD;
                    len_next   = len_reg + sexp_pkg::TEXT_LEN_W'(room0)
                                         + sexp_pkg::TEXT_LEN_W'(room1);
                    trunc_next = trunc_reg || !room1;
                end
                else
                begin
                    if (mode_reg == sexp_pkg::MODE_NUMWORD)
                    begin
                        if (c_digit)
                            digit_next = 1'b1;
                        else if (in_byte == sexp_pkg::CH_POINT)
                            point_next = (point_reg < 2'd2) ? point_reg + 2'd1 : point_reg;
                        else
                            nondig_next = 1'b1;
                    end
                    if (room0)
                        len_next = len_plus1[sexp_pkg::TEXT_LEN_W-1:0];
                    else
                        trunc_next = 1'b1;
                end
            end
            default:
            begin
                {digit_next, point_next, nondig_next, len_next, trunc_next} = '0;
                mode_next = sexp_pkg::MODE_IDLE;
                if (!is_end)
                begin
                    mode_next  = idle_mode;
                    digit_next = c_digit;
                    len_next   = sexp_pkg::TEXT_LEN_W'(idle_emit && !idle_rec.result_kind);
                end
            end
        endcase
    end

    // results of this beat
    always_comb
    begin
        r0    = sexp_pkg::make_text(8'd0);
        r1    = sexp_pkg::make_text(8'd0);
        n_res = 2'd0;
        unique case (mode_reg)
            sexp_pkg::MODE_COMMENT:
            begin
                if (is_end)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_EOF, trunc_reg);
                    n_res = 2'd1;
                end
            end
            sexp_pkg::MODE_STRING:
            begin
                if (is_end)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_ERROR, trunc_reg);
                    n_res = 2'd1;
                end
                else if (in_byte == sexp_pkg::CH_QUOTE)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_STRING, trunc_reg);
                    n_res = 2'd1;
                end
                else if (in_byte != sexp_pkg::CH_BSLASH && room0)
                begin
                    r0    = sexp_pkg::make_text(in_byte);
                    n_res = 2'd1;
                end
            end
            sexp_pkg::MODE_ESCAPE:
            begin
                if (is_end)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_ERROR, trunc_reg);
                    n_res = 2'd1;
                end
                else if (room0)
                begin
                    r0    = sexp_pkg::make_text(esc_char);
                    n_res = 2'd1;
                end
            end
            sexp_pkg::MODE_HASH:
            begin
                if (is_end)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_ERROR, trunc_reg);
                    n_res = 2'd1;
                end
                else if (in_byte == sexp_pkg::CH_LOW_T)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_TRUE, trunc_reg);
                    n_res = 2'd1;
                end
                else if (in_byte == sexp_pkg::CH_LOW_F)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_FALSE, trunc_reg);
                    n_res = 2'd1;
                end
                else if (in_byte != sexp_pkg::CH_QMARK)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_ERROR, trunc_reg);
                    n_res = 2'd1;
                end
            end
            sexp_pkg::MODE_HASHQ:
            begin
                n_res = 2'd1;
                if (!is_end && in_byte == sexp_pkg::CH_LPAREN)
                    r0 = sexp_pkg::make_end(sexp_pkg::KIND_PATOPEN, trunc_reg);
                else
                    r0 = sexp_pkg::make_end(sexp_pkg::KIND_ERROR, trunc_reg);
            end
            sexp_pkg::MODE_NUMWORD, sexp_pkg::MODE_SYMWORD, sexp_pkg::MODE_DOT:
            begin
                if (c_term)
                begin
                    if (mode_reg == sexp_pkg::MODE_DOT)
                        r0 = sexp_pkg::make_end(sexp_pkg::KIND_DOT, trunc_reg);
                    else if (mode_reg == sexp_pkg::MODE_NUMWORD)
                        r0 = sexp_pkg::make_end(word_kind, trunc_reg);
                    else
                        r0 = sexp_pkg::make_end(sexp_pkg::KIND_SYMBOL, trunc_reg);
                    n_res = 2'd1;
                    if (is_end)
                    begin
                        r1    = sexp_pkg::make_end(sexp_pkg::KIND_EOF, 1'b0);
                        n_res = 2'd2;
                    end
                    else if (idle_emit)
                    begin
                        r1    = idle_rec;
                        n_res = 2'd2;
                    end
                end
                else if (mode_reg == sexp_pkg::MODE_DOT)
                begin
                    // pending point turns into the first character of a symbol
                    r0    = sexp_pkg::make_text(sexp_pkg::CH_POINT);
                    r1    = sexp_pkg::make_text(in_byte);
                    n_res = {room1, room0 && !room1};
                end
                else if (room0)
                begin
                    r0    = sexp_pkg::make_text(in_byte);
                    n_res = 2'd1;
                end
            end
            default:
            begin
                if (is_end)
                begin
                    r0    = sexp_pkg::make_end(sexp_pkg::KIND_EOF, trunc_reg);
                    n_res = 2'd1;
                end
                else if (idle_emit)
                begin
                    r0    = idle_rec;
                    n_res = 2'd1;
                end
            end
        endcase
    end

    assign push              = take && (n_res != 2'd0);
    assign push_entry.two    = n_res[1];
    assign push_entry.first  = r0;
    assign push_entry.second = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sexp_pkg::MODE_IDLE;
            digit_reg  <= 1'b0;
            point_reg  <= 2'd0;
            nondig_reg <= 1'b0;
            len_reg    <= '0;
            trunc_reg  <= 1'b0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            digit_reg  <= digit_next;
            point_reg  <= point_next;
            nondig_reg <= nondig_next;
            len_reg    <= len_next;
            trunc_reg  <= trunc_next;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= sexp_pkg::TEXT_LEN_MAX)
        else $error("text length beyond limit");

    a_trunc_full: assert property (@(posedge clk) disable iff (!rst_n)
        trunc_reg |-> (len_reg == sexp_pkg::TEXT_LEN_MAX))
        else $error("truncation flagged before text was full");

    a_dot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sexp_pkg::MODE_DOT) |-> (len_reg == '0 && !trunc_reg))
        else $error("pending dot with text state");

endmodule

/* rtl/core/sexp_fifo.sv */
// ----------------------------------------------------------------------------
// sexp_fifo: result queue
// Small flop queue of per-beat result entries between scanner and serializer.
// ----------------------------------------------------------------------------
module sexp_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sexp_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output sexp_pkg::entry_t head
);

    sexp_pkg::entry_t                 mem_reg [sexp_pkg::FIFO_DEPTH];
    logic [sexp_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [sexp_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [sexp_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == sexp_pkg::FIFO_CNT_W'(sexp_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + sexp_pkg::FIFO_PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + sexp_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + sexp_pkg::FIFO_CNT_W'(push) - sexp_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overflow or underflow");

endmodule

/* rtl/core/sexp_back.sv */
// ----------------------------------------------------------------------------
// sexp_back: result serializer
// Sends the one or two results of each queue entry as separate output beats.
// ----------------------------------------------------------------------------
module sexp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  sexp_pkg::entry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output sexp_pkg::result_t cur,
    output logic             last
);

    logic sel_reg, sel_next;
    logic beat;

    assign out_valid = !empty;
    assign beat      = out_valid && out_ready;
    assign cur       = sel_reg ? head.second : head.first;
    assign last      = sel_reg || !head.two;
    assign pop       = beat && last;

    always_comb
    begin
        sel_next = sel_reg;
        if (beat)
            sel_next = !last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

    a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (!empty && head.two))
        else $error("second result selected without a pair");

    a_sel_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sel_reg) |-> $past(beat && head.two))
        else $error("second result selected without first beat");

endmodule

/* rtl/core/s_expression_tokenizer.sv */
// ----------------------------------------------------------------------------
// s_expression_tokenizer: streaming s-expression lexer
// Byte-per-beat tokenizer with a decoupled scanner and result serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one character per beat in in_byte, or
//   an end-of-stream beat with is_end set (in_byte then ignored).
//   Output channel (out_valid/out_ready): one result per beat. result_kind 0
//   is a text byte of the current token (text_byte, escapes translated);
//   result_kind 1 ends a token and gives token_kind and truncated. last marks
//   the final result caused by one input beat.
//   Results of a beat are registered in the queue when the beat is accepted
//   and are driven onto the output from the queue head.
//   Throughput: one input beat per cycle while in_ready is high. A beat causes
//   zero, one or two results; the output drains one result per cycle while
//   out_ready is high, so only beats with two results (a word end followed by
//   a delimiter token or eof, or a dot turning into a symbol) need two beats.
//   A four-entry queue sits between the scanner and the serializer; when the
//   receiver stalls the queue fills and in_ready drops while it is full.
//   Reset: scanner idle between tokens, text state cleared, queue empty.
// ----------------------------------------------------------------------------
module s_expression_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       is_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] text_byte,
    output logic [3:0] token_kind,
    output logic       truncated,
    output logic       last
);

    logic              take;
    logic              push;
    sexp_pkg::entry_t  push_entry;
    logic              pop;
    logic              full;
    logic              empty;
    sexp_pkg::entry_t  head;
    sexp_pkg::result_t cur;

    // scanner runs whenever the queue has room for this beat's entry
    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    sexp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .in_byte    (in_byte),
        .is_end     (is_end),
        .push       (push),
        .push_entry (push_entry)
    );

    sexp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    sexp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cur        (cur),
        .last       (last)
    );

    assign result_kind = cur.result_kind;
    assign text_byte   = cur.text_byte;
    assign token_kind  = cur.token_kind;
    assign truncated   = cur.truncated;

endmodule

/* tb/s_expression_tokenizer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_expression_tokenizer_checker: result checker for the s-expression lexer
// Watches both channels, runs its own lexer on every accepted input beat and
// compares each accepted output beat, field by field, with the oldest result
// still due.
// ----------------------------------------------------------------------------
module s_expression_tokenizer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       is_end,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       result_kind,
    input  logic [7:0] text_byte,
    input  logic [3:0] token_kind,
    input  logic       truncated,
    input  logic       last,
    output int         mismatch_count,
    output int         pending_results
);

    typedef struct packed {
        sexp_pkg::result_t res;
        logic              last;
    } lexed_result_t;

    // lexer state
    sexp_pkg::scan_mode_t lex_mode      = sexp_pkg::MODE_IDLE;
    logic                 digit_seen    = 1'b0;
    logic                 nondigit_seen = 1'b0;
    logic                 trunc_flag    = 1'b0;
    logic [1:0]           point_count   = 2'd0;
    int                   text_len      = 0;

    lexed_result_t     results_due[$];
    sexp_pkg::result_t beat_results[$];

    function automatic logic is_space(input logic [7:0] ch);
        return ch == sexp_pkg::CH_SPACE || (ch >= sexp_pkg::CH_TAB && ch <= sexp_pkg::CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= sexp_pkg::CH_ZERO && ch <= sexp_pkg::CH_NINE;
    endfunction

    function automatic logic ends_word(input logic [7:0] ch);
        return is_space(ch) || ch == sexp_pkg::CH_QUOTE || ch == sexp_pkg::CH_LPAREN ||
               ch == sexp_pkg::CH_RPAREN || ch == sexp_pkg::CH_SEMI;
    endfunction

    task automatic clear_text();
        digit_seen    = 1'b0;
        point_count   = 2'd0;
        nondigit_seen = 1'b0;
        text_len      = 0;
        trunc_flag    = 1'b0;
    endtask

    // text past the limit is dropped but remembered
    task automatic add_text(input logic [7:0] ch);
        sexp_pkg::result_t r;
        if (text_len < sexp_pkg::MAX_TEXT_LENGTH) begin
            r.result_kind = sexp_pkg::RES_TEXT;
            r.text_byte   = ch;
            r.token_kind  = sexp_pkg::KIND_EOF;
            r.truncated   = 1'b0;
            beat_results  = {beat_results, r};
            text_len++;
        end
        else
            trunc_flag = 1'b1;
    endtask

    task automatic close_token(input logic [3:0] kind);
        sexp_pkg::result_t r;
        r.result_kind = sexp_pkg::RES_END;
        r.text_byte   = 8'd0;
        r.token_kind  = kind;
        r.truncated   = trunc_flag;
        beat_results  = {beat_results, r};
        clear_text();
        lex_mode = sexp_pkg::MODE_IDLE;
    endtask

    function automatic logic [3:0] number_kind();
        if (nondigit_seen || !digit_seen || point_count >= 2'd2)
            return sexp_pkg::KIND_SYMBOL;
        if (point_count == 2'd1)
            return sexp_pkg::KIND_REAL;
        return sexp_pkg::KIND_INTEGER;
    endfunction

    // character seen between tokens
    task automatic open_token(input logic [7:0] ch);
        clear_text();
        lex_mode = sexp_pkg::MODE_IDLE;
        if (ch == sexp_pkg::CH_SEMI)
            lex_mode = sexp_pkg::MODE_COMMENT;
        else if (ch == sexp_pkg::CH_LPAREN)
            close_token(sexp_pkg::KIND_OPEN);
        else if (ch == sexp_pkg::CH_RPAREN)
            close_token(sexp_pkg::KIND_CLOSE);
        else if (ch == sexp_pkg::CH_QUOTE)
            lex_mode = sexp_pkg::MODE_STRING;
        else if (ch == sexp_pkg::CH_HASH)
            lex_mode = sexp_pkg::MODE_HASH;
        else if (is_digit(ch) || ch == sexp_pkg::CH_MINUS)
        begin
            lex_mode   = sexp_pkg::MODE_NUMWORD;
            digit_seen = is_digit(ch);
            add_text(ch);
        end
        else if (ch == sexp_pkg::CH_POINT)
            lex_mode = sexp_pkg::MODE_DOT;
        else if (!is_space(ch))
        begin
            lex_mode = sexp_pkg::MODE_SYMWORD;
            add_text(ch);
        end
    endtask

    task automatic lex_char(input logic [7:0] ch, input logic eos);
        lexed_result_t due;
        beat_results.delete();
        case (lex_mode)
            sexp_pkg::MODE_COMMENT:
                if (eos)
                    close_token(sexp_pkg::KIND_EOF);
                else if (ch == sexp_pkg::CH_LF)
                    lex_mode = sexp_pkg::MODE_IDLE;
            sexp_pkg::MODE_STRING:
                if (eos)
                    close_token(sexp_pkg::KIND_ERROR);
                else if (ch == sexp_pkg::CH_QUOTE)
                    close_token(sexp_pkg::KIND_STRING);
                else if (ch == sexp_pkg::CH_BSLASH)
                    lex_mode = sexp_pkg::MODE_ESCAPE;
                else
                    add_text(ch);
            sexp_pkg::MODE_ESCAPE:
                if (eos)
                    close_token(sexp_pkg::KIND_ERROR);
                else
                begin
                    lex_mode = sexp_pkg::MODE_STRING;
                    if (ch == sexp_pkg::CH_LOW_N)
                        add_text(sexp_pkg::CH_LF);
                    else if (ch == sexp_pkg::CH_LOW_T)
                        add_text(sexp_pkg::CH_TAB);
                    else
                        add_text(ch);
                end
            sexp_pkg::MODE_HASH:
                if (!eos && ch == sexp_pkg::CH_LOW_T)
                    close_token(sexp_pkg::KIND_TRUE);
                else if (!eos && ch == sexp_pkg::CH_LOW_F)
                    close_token(sexp_pkg::KIND_FALSE);
                else if (!eos && ch == sexp_pkg::CH_QMARK)
                    lex_mode = sexp_pkg::MODE_HASHQ;
                else
                    close_token(sexp_pkg::KIND_ERROR);
            sexp_pkg::MODE_HASHQ:
                if (!eos && ch == sexp_pkg::CH_LPAREN)
                    close_token(sexp_pkg::KIND_PATOPEN);
                else
                    close_token(sexp_pkg::KIND_ERROR);
            sexp_pkg::MODE_NUMWORD, sexp_pkg::MODE_SYMWORD, sexp_pkg::MODE_DOT:
                if (eos || ends_word(ch))
                begin
                    if (lex_mode == sexp_pkg::MODE_DOT)
                        close_token(sexp_pkg::KIND_DOT);
                    else if (lex_mode == sexp_pkg::MODE_NUMWORD)
                        close_token(number_kind());
                    else
                        close_token(sexp_pkg::KIND_SYMBOL);
                    if (eos)
                        close_token(sexp_pkg::KIND_EOF);
                    else
                        open_token(ch);
                end
                else if (lex_mode == sexp_pkg::MODE_DOT)
                begin
                    // leading point becomes part of a symbol
                    add_text(sexp_pkg::CH_POINT);
                    add_text(ch);
                    lex_mode = sexp_pkg::MODE_SYMWORD;
                end
                else
                begin
                    if (lex_mode == sexp_pkg::MODE_NUMWORD)
                    begin
                        if (is_digit(ch))
                            digit_seen = 1'b1;
                        else if (ch == sexp_pkg::CH_POINT)
                        begin
                            if (point_count < 2'd2)
                                point_count++;
                        end
                        else
                            nondigit_seen = 1'b1;
                    end
                    add_text(ch);
                end
            default:
                if (eos)
                    close_token(sexp_pkg::KIND_EOF);
                else
                    open_token(ch);
        endcase
        foreach (beat_results[i])
        begin
            due.res     = beat_results[i];
            due.last    = (i == beat_results.size() - 1);
            results_due = {results_due, due};
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // output side first: a result never belongs to the beat taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        lexed_result_t due;
        if (!rst_n)
        begin
            lex_mode = sexp_pkg::MODE_IDLE;
            clear_text();
            results_due.delete();
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: extra beat, expected none, actual %0d/%0d/%0d",
                             $time, result_kind, text_byte, token_kind);
                    mismatch_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("result_kind", int'(due.res.result_kind), int'(result_kind));
                    check_field("text_byte", int'(due.res.text_byte), int'(text_byte));
                    check_field("token_kind", int'(due.res.token_kind), int'(token_kind));
                    check_field("truncated", int'(due.res.truncated), int'(truncated));
                    check_field("last", int'(due.last), int'(last));
                end
            end
            if (in_valid && in_ready)
                lex_char(in_byte, is_end);
            pending_results <= results_due.size();
        end
    end

endmodule

/* tb/tb_s_expression_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_s_expression_tokenizer: testbench for the s-expression tokenizer
// Feeds a directed character stream, then random well-formed tokens mixed
// with noise. A checker beside the block predicts and compares every
// result; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_s_expression_tokenizer;

    localparam int RANDOM_BEATS = 750;
    localparam int HOLD_CYCLES  = 60;   // long receiver hold-off, fills the queue
    localparam int DRAIN_CYCLES = 10;   // settle time after the last result

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'd0;
    logic       is_end    = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       result_kind;
    logic [7:0] text_byte;
    logic [3:0] token_kind;
    logic       truncated;
    logic       last;

    int mismatch_count;
    int pending_results;

    // both sides idle at random only while this is set
    bit gaps_on         = 1'b0;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int holds_requested = 0;
    int beats_sent      = 0;

    always #5 clk = ~clk;

    s_expression_tokenizer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .is_end      (is_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .text_byte   (text_byte),
        .token_kind  (token_kind),
        .truncated   (truncated),
        .last        (last)
    );

    s_expression_tokenizer_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .is_end          (is_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .text_byte       (text_byte),
        .token_kind      (token_kind),
        .truncated       (truncated),
        .last            (last),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // One beat: optional idle cycles with valid low, then hold valid and the
    // payload until the block takes it. in_ready is read right after the edge,
    // so it is the value that decided acceptance at that edge.
    task automatic send_beat(input logic [7:0] ch, input logic eos);
        while (gaps_on && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= ch;
        is_end   <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // Stop offering and wait until the checker has nothing due. The first
    // edge lets the checker count the beat accepted just now.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // A character that neither starts a comment, string or paren nor counts
    // as whitespace. With no_digit set it also cannot open a number, a dot or
    // a '#' form, so it starts a symbol.
    function automatic logic [7:0] pick_plain(input bit no_digit);
        logic [7:0] ch;
        case ($urandom_range(0, no_digit ? 3 : 4))
            0:       ch = 8'($urandom_range(128, 255));
            1:       ch = 8'($urandom_range(0, 8));
            2:       ch = 8'($urandom_range(14, 31));
            3:       ch = 8'($urandom_range(60, 126));
            default: ch = 8'($urandom_range(42, 58));
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] pick_space();
        int sel;
        sel = $urandom_range(0, 5);
        return (sel == 5) ? sexp_pkg::CH_SPACE : 8'(sexp_pkg::CH_TAB + sel);
    endfunction

    // What follows a word: mostly a delimiter, sometimes end of stream,
    // sometimes nothing so the next token runs into the word.
    task automatic send_word_end();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            send_beat(pick_space(), 1'b0);
        else if (sel == 5)
            send_beat(sexp_pkg::CH_LPAREN, 1'b0);
        else if (sel == 6)
            send_beat(sexp_pkg::CH_RPAREN, 1'b0);
        else if (sel == 7)
            send_beat(rand_byte(), 1'b1);
    endtask

    // One random token, mostly well formed with random content.
    task automatic send_random_token();
        int         sel;
        int         len;
        logic [7:0] ch;
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            len = $urandom_range(1, 3);
            repeat (len) send_beat(pick_space(), 1'b0);
        end
        else if (sel < 24)
            send_beat($urandom_range(0, 1) ? sexp_pkg::CH_LPAREN : sexp_pkg::CH_RPAREN, 1'b0);
        else if (sel < 42)
        begin
            // number-like word: digits and points, now and then a stray char
            if ($urandom_range(0, 4) == 0)
                ch = sexp_pkg::CH_MINUS;
            else
                ch = 8'(sexp_pkg::CH_ZERO + $urandom_range(0, 9));
            send_beat(ch, 1'b0);
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    ch = 8'(sexp_pkg::CH_ZERO + $urandom_range(0, 9));
                else if (sel < 82)
                    ch = sexp_pkg::CH_POINT;
                else
                    ch = pick_plain(1'b0);
                send_beat(ch, 1'b0);
            end
            send_word_end();
        end
        else if (sel < 54)
        begin
            send_beat(pick_plain(1'b1), 1'b0);
            len = $urandom_range(0, 5);
            repeat (len) send_beat(pick_plain(1'b0), 1'b0);
            send_word_end();
        end
        else if (sel < 60)
        begin
            // lone dot, or a dot that grows into a symbol
            send_beat(sexp_pkg::CH_POINT, 1'b0);
            len = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
            repeat (len) send_beat(pick_plain(1'b0), 1'b0);
            send_word_end();
        end
        else if (sel < 74)
        begin
            send_beat(sexp_pkg::CH_QUOTE, 1'b0);
            len = $urandom_range(0, 8);
            repeat (len)
            begin
                ch = rand_byte();
                if (ch == sexp_pkg::CH_QUOTE || ch == sexp_pkg::CH_BSLASH
                    || $urandom_range(0, 99) < 15)
                begin
                    // escape: \n, \t or any other byte taken as is
                    send_beat(sexp_pkg::CH_BSLASH, 1'b0);
                    sel = $urandom_range(0, 2);
                    send_beat(sel == 0 ? sexp_pkg::CH_LOW_N :
                              sel == 1 ? sexp_pkg::CH_LOW_T : ch, 1'b0);
                end
                else
                    send_beat(ch, 1'b0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 85)
                send_beat(sexp_pkg::CH_QUOTE, 1'b0);
            else if (sel < 93)
                send_beat(rand_byte(), 1'b1);               // stream ends in the string
            else
            begin
                send_beat(sexp_pkg::CH_BSLASH, 1'b0);       // ... or in an escape
                send_beat(rand_byte(), 1'b1);
            end
        end
        else if (sel < 82)
        begin
            send_beat(sexp_pkg::CH_HASH, 1'b0);
            sel = $urandom_range(0, 5);
            case (sel)
                0: send_beat(sexp_pkg::CH_LOW_T, 1'b0);
                1: send_beat(sexp_pkg::CH_LOW_F, 1'b0);
                2:
                begin
                    send_beat(sexp_pkg::CH_QMARK, 1'b0);
                    send_beat(sexp_pkg::CH_LPAREN, 1'b0);
                end
                3:
                begin
                    send_beat(sexp_pkg::CH_QMARK, 1'b0);
                    send_beat(rand_byte(), $urandom_range(0, 3) == 0);
                end
                4: send_beat(rand_byte(), 1'b0);
                default: send_beat(rand_byte(), 1'b1);
            endcase
        end
        else if (sel < 88)
        begin
            send_beat(sexp_pkg::CH_SEMI, 1'b0);
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                ch = rand_byte();
                send_beat(ch == sexp_pkg::CH_LF ? sexp_pkg::CH_SPACE : ch, 1'b0);
            end
            if ($urandom_range(0, 9) == 0)
                send_beat(rand_byte(), 1'b1);
            else
                send_beat(sexp_pkg::CH_LF, 1'b0);
        end
        else if (sel < 92)
            send_beat(rand_byte(), 1'b1);
        else
        begin
            // raw noise over the whole byte range
            len = $urandom_range(1, 3);
            repeat (len)
                send_beat(rand_byte(), $urandom_range(0, 15) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls while gaps are on, plus a counted
    // hold-off each time the stimulus asks for one.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_requested)
            begin
                holds_served = holds_requested;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !(gaps_on && $urandom_range(99) < 20);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        int start;
        int done;
        int pauses;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a number closed by ')' (two ends in one beat), byte 0 as a
        // symbol, #t, #?(, a bad '#' form with byte 255, a dot growing into a
        // symbol closed by '"', an unknown escape and \n, and a real cut off
        // by end of stream. No idling here.
        send_text("(-7)");
        send_beat(8'h00, 1'b0);
        send_text(" #t#?(#");
        send_beat(8'hFF, 1'b0);
        send_text(".5\"\\q\\n\"1.");
        send_beat(8'h00, 1'b1);
        wait_drained();

        // Random tokens. One stretch runs with no idling on either side; two
        // long receiver hold-offs while the sender keeps offering; two pauses
        // where the sender waits for every result.
        pauses = 0;
        start  = beats_sent;
        done   = 0;
        while (done < RANDOM_BEATS)
        begin
            gaps_on = !(done >= 250 && done < 400);
            if (done >= 100 && holds_requested == 0)
                holds_requested = 1;
            if (done >= 500 && holds_requested == 1)
                holds_requested = 2;
            if ((done >= 200 && pauses == 0) || (done >= 650 && pauses == 1))
            begin
                wait_drained();
                pauses++;
            end
            send_random_token();
            done = beats_sent - start;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial
    begin
        #500000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sexp_pkg.sv
rtl/core/sexp_front.sv
rtl/core/sexp_fifo.sv
rtl/core/sexp_back.sv
rtl/core/s_expression_tokenizer.sv
tb/s_expression_tokenizer_checker.sv
tb/tb_s_expression_tokenizer.sv
